>>> rtl/core/bucket_sort_engine_unit_assert.svh
// Assertion macros for the bucket sort engine
`ifndef BUCKET_SORT_ENGINE_UNIT_ASSERT_SVH
`define BUCKET_SORT_ENGINE_UNIT_ASSERT_SVH

// Check that an implication holds at every clock edge outside reset
`define BSE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that an implication holds in the next cycle
`define BSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/bse_pkg.sv
package bse_pkg;

  localparam int unsigned NumBuckets  = 8;
  localparam int unsigned BucketDepth = 64;
  localparam int unsigned MaxItems    = 64;

  localparam int unsigned BktW  = $clog2(NumBuckets);
  localparam int unsigned SlotW = $clog2(BucketDepth);
  localparam int unsigned ItemW = $clog2(MaxItems);
  localparam int unsigned CntW  = ItemW + 1;
  localparam int unsigned FillW = SlotW + 1;
  localparam int unsigned StoreW = BktW + SlotW;
  localparam int unsigned NumW  = 32 + BktW;

  typedef logic [31:0] word_t;

  typedef enum logic [3:0] {
    StLoad,
    StDistRd,
    StDivide,
    StPlace,
    StSortInit,
    StSortRd,
    StSortCmp,
    StSortWr,
    StEmitRd,
    StEmitOut
  } state_e;

  // Divider handshake between the controller and the bucket index unit
  typedef struct packed {
    logic             start;
    logic [NumW-1:0]  num;
    logic [31:0]      den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NumW-1:0]  quo;
  } div_rsp_t;

endpackage

>>> rtl/core/bse_divider.sv
module bse_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bse_pkg::div_req_t req_i,
  output bse_pkg::div_rsp_t rsp_o
);
  import bse_pkg::*;

  localparam int unsigned StepW = $clog2(NumW + 1);

  logic [NumW-1:0]  quo_q, quo_d;
  logic [31:0]      rem_q, rem_d;
  logic [31:0]      den_q, den_d;
  logic [StepW-1:0] step_q, step_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [32:0]      trial;

  // Restoring division, one quotient bit a cycle
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = '0;
    if (req_i.start) begin
      quo_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      step_d = StepW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, quo_q[NumW-1]};
      if (trial >= {1'b0, den_q}) begin
        rem_d = 32'(trial - {1'b0, den_q});
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial[31:0];
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      step_d = step_q - 1'b1;
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

>>> rtl/core/bucket_sort_engine_unit.sv
// Bucket sort engine: loads signed Q16.16 values, emits them sorted per set.
// Load: start is taken whenever busy is low, one transaction per cycle while busy stays low.
// Distribute: each value is read, divided to find its bucket and placed; no divide when all values are equal.
// Sort: each key is read, compared and shifted, then written; emit: each result is read, then shown.
// Results cannot be stalled: each is shown for one cycle with result_valid_o.
// rst_ni clears control state asynchronously; the memories are not cleared.
module bucket_sort_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] sample_value_i,
  input  logic        last_item_i,
  output logic        result_valid_o,
  output logic [31:0] sorted_value_o,
  output logic        last_result_o,
  output logic        items_dropped_o
);
  import bse_pkg::*;
  `include "bucket_sort_engine_unit_assert.svh"

  state_e state_q, state_d;

  // Load buffer and bucket store
  word_t load_mem [MaxItems];
  word_t store_mem [NumBuckets*BucketDepth];
  word_t load_rd_q, store_rd_q;
  logic              load_we;
  logic [ItemW-1:0]  load_wa, load_ra;
  logic              store_we;
  logic [StoreW-1:0] store_wa, store_ra;
  word_t             store_wd;

  logic [CntW-1:0]  cnt_q, cnt_d;
  word_t            min_q, min_d, max_q, max_d;
  logic             ovf_q, ovf_d;
  logic [FillW-1:0] fill_q [NumBuckets];
  logic [FillW-1:0] fill_d [NumBuckets];
  logic [CntW-1:0]  idx_q, idx_d;
  word_t            val_q, val_d;
  logic [BktW-1:0]  bkt_q, bkt_d;
  logic [SlotW-1:0] k_q, k_d, pos_q, pos_d;
  logic [FillW-1:0] emit_q, emit_d;
  logic             out_v_q, out_v_d, out_l_q, out_l_d, out_o_q, out_o_d;
  word_t            out_x_q, out_x_d;

  div_req_t div_req;
  div_rsp_t div_rsp;
  word_t    span;
  logic     accept;

  bse_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign span   = max_q - min_q;
  assign accept = start && !busy;
  assign busy   = (state_q != StLoad);

  always_ff @(posedge clk_i) begin
    if (load_we) load_mem[load_wa] <= sample_value_i;
    load_rd_q <= load_mem[load_ra];
  end

  always_ff @(posedge clk_i) begin
    if (store_we) store_mem[store_wa] <= store_wd;
    store_rd_q <= store_mem[store_ra];
  end

  // Sequence load, distribute, per-bucket insertion sort and emit
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    min_d    = min_q;
    max_d    = max_q;
    ovf_d    = ovf_q;
    fill_d   = fill_q;
    idx_d    = idx_q;
    val_d    = val_q;
    bkt_d    = bkt_q;
    k_d      = k_q;
    pos_d    = pos_q;
    emit_d   = emit_q;
    out_v_d  = 1'b0;
    out_l_d  = 1'b0;
    out_o_d  = ovf_q;
    out_x_d  = out_x_q;
    load_we  = 1'b0;
    load_wa  = cnt_q[ItemW-1:0];
    load_ra  = idx_q[ItemW-1:0];
    store_we = 1'b0;
    store_wa = '0;
    store_wd = val_q;
    store_ra = {bkt_q, pos_q};
    div_req.start = 1'b0;
    div_req.num   = {(val_q - min_q), {BktW{1'b0}}};
    div_req.den   = span;
    unique case (state_q)
      StLoad: begin
        if (accept) begin
          if (cnt_q < CntW'(MaxItems)) begin
            load_we = 1'b1;
            if (cnt_q == '0) begin
              min_d = sample_value_i;
              max_d = sample_value_i;
            end else begin
              if ($signed(sample_value_i) < $signed(min_q)) min_d = sample_value_i;
              if ($signed(sample_value_i) > $signed(max_q)) max_d = sample_value_i;
            end
            cnt_d = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (last_item_i) begin
            idx_d   = '0;
            state_d = StDistRd;
          end
        end
      end
      StDistRd: begin
        if (idx_q == cnt_q) begin
          bkt_d   = '0;
          state_d = StSortInit;
        end else begin
          state_d = StDivide;
        end
      end
      StDivide: begin
        // load_rd_q is valid now; hold it and start the divide unless the span is zero
        val_d = load_rd_q;
        if (span == '0) begin
          bkt_d   = '0;
          state_d = StPlace;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = {(load_rd_q - min_q), {BktW{1'b0}}};
          state_d       = StPlace;
          bkt_d         = {BktW{1'b1}};
          pos_d         = '1;
        end
      end
      StPlace: begin
        if (span == '0 || div_rsp.done) begin
          if (span != '0) begin
            if (div_rsp.quo >= NumW'(NumBuckets)) bkt_d = BktW'(NumBuckets - 1);
            else bkt_d = div_rsp.quo[BktW-1:0];
          end
          if (fill_q[bkt_d] < FillW'(BucketDepth)) begin
            store_we = 1'b1;
            store_wa = {bkt_d, fill_q[bkt_d][SlotW-1:0]};
            store_wd = val_q;
            fill_d[bkt_d] = fill_q[bkt_d] + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          idx_d   = idx_q + 1'b1;
          load_ra = idx_d[ItemW-1:0];
          state_d = StDistRd;
        end
      end
      StSortInit: begin
        // Start insertion at k = 1 of the current bucket
        k_d = SlotW'(1);
        if (fill_q[bkt_q] <= FillW'(1)) begin
          emit_d  = '0;
          state_d = StEmitRd;
        end else begin
          store_ra = {bkt_q, SlotW'(1)};
          state_d  = StSortRd;
        end
      end
      StSortRd: begin
        // store_rd_q holds slot[k]; read slot[k-1]
        val_d    = store_rd_q;
        pos_d    = k_q;
        store_ra = {bkt_q, k_q - 1'b1};
        state_d  = StSortCmp;
      end
      StSortCmp: begin
        if ($signed(store_rd_q) > $signed(val_q)) begin
          store_we = 1'b1;
          store_wa = {bkt_q, pos_q};
          store_wd = store_rd_q;
          pos_d    = pos_q - 1'b1;
          if (pos_q == SlotW'(1)) begin
            state_d = StSortWr;
          end else begin
            store_ra = {bkt_q, pos_q - SlotW'(2)};
            state_d  = StSortCmp;
          end
        end else begin
          state_d = StSortWr;
        end
      end
      StSortWr: begin
        store_we = 1'b1;
        store_wa = {bkt_q, pos_q};
        store_wd = val_q;
        if ({1'b0, k_q} + 1'b1 >= fill_q[bkt_q]) begin
          emit_d  = '0;
          state_d = StEmitRd;
        end else begin
          k_d      = k_q + 1'b1;
          store_ra = {bkt_q, k_d};
          state_d  = StSortRd;
        end
      end
      StEmitRd: begin
        if (emit_q == fill_q[bkt_q]) begin
          if (bkt_q == BktW'(NumBuckets - 1)) begin
            cnt_d   = '0;
            min_d   = '0;
            max_d   = '0;
            ovf_d   = 1'b0;
            for (int b = 0; b < NumBuckets; b++) fill_d[b] = '0;
            state_d = StLoad;
          end else begin
            bkt_d   = bkt_q + 1'b1;
            state_d = StSortInit;
          end
        end else begin
          store_ra = {bkt_q, emit_q[SlotW-1:0]};
          state_d  = StEmitOut;
        end
      end
      StEmitOut: begin
        out_v_d = 1'b1;
        out_x_d = store_rd_q;
        out_l_d = 1'b1;
        for (int b = 0; b < NumBuckets; b++) begin
          if (BktW'(b) > bkt_q && fill_q[b] != '0) out_l_d = 1'b0;
        end
        if (emit_q + 1'b1 != fill_q[bkt_q]) out_l_d = 1'b0;
        emit_d  = emit_q + 1'b1;
        state_d = StEmitRd;
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      cnt_q   <= '0;
      min_q   <= '0;
      max_q   <= '0;
      ovf_q   <= 1'b0;
      out_v_q <= 1'b0;
      for (int b = 0; b < NumBuckets; b++) fill_q[b] <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      min_q   <= min_d;
      max_q   <= max_d;
      ovf_q   <= ovf_d;
      out_v_q <= out_v_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    val_q   <= val_d;
    bkt_q   <= bkt_d;
    k_q     <= k_d;
    pos_q   <= pos_d;
    emit_q  <= emit_d;
    out_l_q <= out_l_d;
    out_o_q <= out_o_d;
    out_x_q <= out_x_d;
  end

  assign result_valid_o  = out_v_q;
  assign sorted_value_o  = out_x_q;
  assign last_result_o   = out_l_q;
  assign items_dropped_o = out_o_q;

  `BSE_ASSERT_IMPL(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= CntW'(MaxItems),
    "item count beyond buffer depth")
  `BSE_ASSERT_IMPL(a_no_out_load, clk_i, rst_ni, state_q == StLoad,
    !result_valid_o, "unexpected result while loading")
  `BSE_ASSERT_NEXT(a_last_idle, clk_i, rst_ni, result_valid_o && last_result_o,
    !result_valid_o, "result after last")
  `BSE_ASSERT_IMPL(a_busy_state, clk_i, rst_ni, result_valid_o, busy,
    "result while idle")

endmodule

>>> dv/bucket_sort_engine_unit_tb.sv
`timescale 1ns / 1ps

module bucket_sort_engine_unit_tb;
  import bse_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
  } sample_t;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
    logic        dropped;
  } sorted_t;

  localparam int unsigned CycleLimit = 3000000;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [31:0] sample_value_i;
  logic        last_item_i;
  logic        result_valid_o;
  logic [31:0] sorted_value_o;
  logic        last_result_o;
  logic        items_dropped_o;

  sample_t     pending_q[$];
  sorted_t     sorted_expect_q[$];
  int unsigned mismatch_count;
  int unsigned result_count;
  int unsigned set_count;
  int unsigned drop_set_count;
  int unsigned cycle_count;
  int unsigned idle_left;
  bit          hold_for_drain;
  bit          pause_req;

  // Predictor state for the set being loaded
  logic [31:0] set_buf[MaxItems];
  int unsigned set_len;
  logic [31:0] set_min;
  logic [31:0] set_max;
  bit          set_overflow;

  bucket_sort_engine_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .sample_value_i (sample_value_i),
    .last_item_i    (last_item_i),
    .result_valid_o (result_valid_o),
    .sorted_value_o (sorted_value_o),
    .last_result_o  (last_result_o),
    .items_dropped_o(items_dropped_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Load one value; on the last mark, bucket, sort and queue the whole set
  task automatic predict_sorted(input sample_t s);
    logic [31:0] bkt[NumBuckets][$];
    logic [31:0] held;
    logic [63:0] span;
    logic [63:0] quo;
    int unsigned b;
    int          p;
    sorted_t     r;
    int unsigned total;
    int unsigned emitted;
    if (set_len < MaxItems) begin
      if (set_len == 0) begin
        set_min = s.value;
        set_max = s.value;
      end else begin
        if ($signed(s.value) < $signed(set_min)) set_min = s.value;
        if ($signed(s.value) > $signed(set_max)) set_max = s.value;
      end
      set_buf[set_len] = s.value;
      set_len++;
    end else begin
      set_overflow = 1'b1;
    end
    if (!s.last) return;
    span = {32'd0, set_max - set_min};
    for (int k = 0; k < set_len; k++) begin
      b = 0;
      if (span != 0) begin
        quo = ({32'd0, set_buf[k] - set_min} * NumBuckets) / span;
        b = (quo >= NumBuckets) ? NumBuckets - 1 : int'(quo);
      end
      if (bkt[b].size() < BucketDepth) bkt[b].push_back(set_buf[k]);
      else set_overflow = 1'b1;
    end
    total = 0;
    for (int i = 0; i < NumBuckets; i++) begin
      total += bkt[i].size();
    end
    emitted = 0;
    for (int i = 0; i < NumBuckets; i++) begin
      // stable insertion sort on signed values
      for (int k = 1; k < bkt[i].size(); k++) begin
        held = bkt[i][k];
        p = k;
        while (p > 0 && $signed(bkt[i][p-1]) > $signed(held)) begin
          bkt[i][p] = bkt[i][p-1];
          p--;
        end
        bkt[i][p] = held;
      end
      foreach (bkt[i][k]) begin
        emitted++;
        r.value   = bkt[i][k];
        r.last    = (emitted == total);
        r.dropped = set_overflow;
        sorted_expect_q.push_back(r);
      end
    end
    set_count++;
    if (set_overflow) drop_set_count++;
    set_len      = 0;
    set_min      = '0;
    set_max      = '0;
    set_overflow = 1'b0;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] pick_value(input int unsigned mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 16) - 8;
      2: return {$urandom_range(0, 1) ? 16'h8000 : 16'h7FFF, 16'($urandom())};
      default: return 32'($signed($urandom_range(0, 2000)) - 1000) << 16;
    endcase
  endfunction

  task automatic queue_set(input int unsigned len, input int unsigned mode);
    sample_t s;
    for (int k = 0; k < len; k++) begin
      s.value = pick_value(mode);
      s.last  = (k == len - 1);
      pending_q.push_back(s);
    end
  endtask

  // Drive transactions from the pending queue with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start          <= 1'b0;
      sample_value_i <= '0;
      last_item_i    <= 1'b0;
      idle_left      <= 0;
      hold_for_drain <= 1'b0;
    end else begin
      automatic bit accepted = start && !busy;
      automatic bit can_send;
      automatic bit pause_now = pause_req && accepted && last_item_i;
      if (accepted) predict_sorted({sample_value_i, last_item_i});
      if (pause_now) hold_for_drain <= 1'b1;
      can_send = !(start && busy) && idle_left == 0 && !hold_for_drain;
      if (hold_for_drain && sorted_expect_q.size() == 0) hold_for_drain <= 1'b0;
      if (start && busy) begin
        // hold the current transaction until taken
      end else if (can_send && pending_q.size() > 0 && !pause_now) begin
        automatic sample_t s = pending_q.pop_front();
        start          <= 1'b1;
        sample_value_i <= s.value;
        last_item_i    <= s.last;
        idle_left      <= pick_gap();
      end else begin
        start <= 1'b0;
        if (idle_left > 0) idle_left <= idle_left - 1;
      end
    end
  end

  // Check every result strobe against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      result_count++;
      if (sorted_expect_q.size() == 0) begin
        $error("unexpected result value=%h", sorted_value_o);
        mismatch_count++;
      end else begin
        automatic sorted_t e = sorted_expect_q.pop_front();
        if (sorted_value_o !== e.value) begin
          $error("sorted_value expected %h actual %h", e.value, sorted_value_o);
          mismatch_count++;
        end
        if (last_result_o !== e.last) begin
          $error("last_result expected %0d actual %0d", e.last, last_result_o);
          mismatch_count++;
        end
        if (items_dropped_o !== e.dropped) begin
          $error("items_dropped expected %0d actual %0d", e.dropped, items_dropped_o);
          mismatch_count++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    sample_t s;
    int unsigned drained;
    mismatch_count = 0;
    result_count   = 0;
    set_count      = 0;
    drop_set_count = 0;
    cycle_count    = 0;
    set_len        = 0;
    set_min        = '0;
    set_max        = '0;
    set_overflow   = 1'b0;
    pause_req      = 1'b0;
    rst_ni         = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: single value, extremes, equal values, tiny span, overflow
    pending_q.push_back({32'h8000_0000, 1'b1});
    pending_q.push_back({32'h7FFF_FFFF, 1'b0});
    pending_q.push_back({32'h8000_0000, 1'b0});
    pending_q.push_back({32'h0000_0000, 1'b0});
    pending_q.push_back({32'hFFFF_FFFF, 1'b0});
    pending_q.push_back({32'h0001_0000, 1'b1});
    repeat (4) pending_q.push_back({32'h0003_8000, 1'b0});
    pending_q.push_back({32'h0003_8000, 1'b1});
    pending_q.push_back({32'h0000_0005, 1'b0});
    pending_q.push_back({32'h0000_0006, 1'b0});
    pending_q.push_back({32'h0000_0005, 1'b1});
    for (int k = 0; k < MaxItems + 3; k++) begin
      s.value = pick_value(0);
      s.last  = (k == MaxItems + 2);
      pending_q.push_back(s);
    end

    // Random sets, mostly short, a few full or overfull
    while (pending_q.size() < 430) begin
      automatic int unsigned roll = $urandom_range(0, 19);
      if (roll == 0) queue_set($urandom_range(MaxItems, MaxItems + 4), $urandom_range(0, 3));
      else queue_set($urandom_range(1, 12), $urandom_range(0, 3));
    end

    // Pause the sender once mid run until everything has drained
    wait (pending_q.size() < 200);
    @(posedge clk_i);
    pause_req <= 1'b1;
    wait (hold_for_drain);
    @(posedge clk_i);
    pause_req <= 1'b0;

    wait (pending_q.size() == 0);
    wait (start == 1'b0 || busy == 1'b0);
    @(posedge clk_i);
    @(posedge clk_i);
    wait (sorted_expect_q.size() == 0 && !start);
    drained = 0;
    while (drained < 200) begin
      @(posedge clk_i);
      drained++;
    end

    $display("covered %0d sets, %0d with drops, %0d sorted results checked",
             set_count, drop_set_count, result_count);
    if (mismatch_count == 0 && sorted_expect_q.size() == 0 && set_len == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results still expected",
               mismatch_count, sorted_expect_q.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
